[hdl/gds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_pkg: shared types and constants of the Gregorian date stepper
// Command and status codes, the item records passed between stages and the
// month length table.
// ----------------------------------------------------------------------------
package gds_pkg;

    localparam int unsigned YearW  = 14;
    localparam int unsigned MonthW = 4;
    localparam int unsigned DayW   = 5;
    localparam int unsigned QuotW  = 8;

    localparam logic [YearW-1:0]  YEAR_MAX = 14'd9999;
    localparam logic [MonthW-1:0] MON_JAN  = 4'd1;
    localparam logic [MonthW-1:0] MON_FEB  = 4'd2;
    localparam logic [MonthW-1:0] MON_DEC  = 4'd12;
    localparam logic [DayW-1:0]   DAY_ONE  = 5'd1;
    localparam logic [DayW-1:0]   WEEK_LEN = 5'd7;

    // Reciprocal of 100 scaled by 2^19; exact for every 14-bit year.
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int unsigned RECIP_SH  = 19;

    typedef enum logic [3:0] {
        CMD_NEXT_DAY        = 4'd0,
        CMD_PREV_DAY        = 4'd1,
        CMD_NEXT_WEEK       = 4'd2,
        CMD_PREV_WEEK       = 4'd3,
        CMD_NEXT_MON_BEGIN  = 4'd4,
        CMD_PREV_MON_BEGIN  = 4'd5,
        CMD_NEXT_MON_END    = 4'd6,
        CMD_PREV_MON_END    = 4'd7,
        CMD_SNAP_END_UP     = 4'd8,
        CMD_SNAP_END_DOWN   = 4'd9,
        CMD_SNAP_BEGIN_UP   = 4'd10,
        CMD_SNAP_BEGIN_DOWN = 4'd11
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef struct packed {
        logic [3:0]        cmd;
        logic [YearW-1:0]  year;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
        logic [QuotW-1:0]  quot;   // year / 100
    } t_item;

    typedef struct packed {
        logic [YearW-1:0]  year;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
        logic [1:0]        status;
    } t_result;

    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                  input logic leap);
        logic [DayW-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

[hdl/gds_cmd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_cmd_if: command channel of the date stepper
// Carries a step command and the date it applies to.
// ----------------------------------------------------------------------------
interface gds_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cmd;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;

    modport source (output valid, output cmd, output year, output month,
                    output day, input ready);
    modport sink   (input valid, input cmd, input year, input month,
                    input day, output ready);
endinterface

[hdl/gds_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_res_if: result channel of the date stepper
// Carries the stepped date and its status code.
// ----------------------------------------------------------------------------
interface gds_res_if;
    logic        valid;
    logic        ready;
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [1:0]  status;

    modport source (output valid, output out_year, output out_month,
                    output out_day, output status, input ready);
    modport sink   (input valid, input out_year, input out_month,
                    input out_day, input status, output ready);
endinterface

[hdl/gds_in_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_in_reg: input register of the date stepper
// Captures a command beat together with year / 100, which feeds the
// century part of the leap year test in the next stage.
// ----------------------------------------------------------------------------
module gds_in_reg
    import gds_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [3:0]        i_cmd,
    input  logic [YearW-1:0]  i_year,
    input  logic [MonthW-1:0] i_month,
    input  logic [DayW-1:0]   i_day,
    input  logic              i_adv,
    output logic              o_valid,
    output t_item             o_item
);

    logic        r_valid;
    t_item       r_item;
    t_item       n_item;
    logic [26:0] quot_prod;

    assign quot_prod = {13'd0, i_year} * {14'd0, RECIP_100};

    always_comb begin
        n_item.cmd   = i_cmd;
        n_item.year  = i_year;
        n_item.month = i_month;
        n_item.day   = i_day;
        n_item.quot  = quot_prod[RECIP_SH +: QuotW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[hdl/gds_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_step: date stepping logic
// Validates the registered date, works out the leap year and the lengths of
// the current and neighboring months, and forms the stepped date and status.
// ----------------------------------------------------------------------------
module gds_step
    import gds_pkg::*;
(
    input  t_item   i_item,
    output t_result o_res
);

    logic [YearW:0]    cent;
    logic              leap;
    logic [DayW-1:0]   cur_len;
    logic [DayW-1:0]   nxt_len;
    logic [DayW-1:0]   prv_len;
    logic [MonthW-1:0] nxt_mon;
    logic [MonthW-1:0] prv_mon;
    logic              is_dec;
    logic              is_jan;
    logic              date_ok;
    logic [DayW:0]     wk_fwd;
    logic [DayW:0]     wk_back;
    logic              to_next;
    logic              to_prev;
    logic [DayW-1:0]   st_day;
    logic              out_range;
    t_result           res;

    // Divisible by 100 exactly when the year equals quotient times 100.
    assign cent = {1'b0, i_item.quot, 6'd0} + {2'b0, i_item.quot, 5'd0}
                + {5'b0, i_item.quot, 2'd0};
    assign leap = (i_item.year[1:0] == 2'b00)
               && ((cent[YearW-1:0] != i_item.year) || (i_item.quot[1:0] == 2'b00));

    assign is_dec  = (i_item.month == MON_DEC);
    assign is_jan  = (i_item.month == MON_JAN);
    assign nxt_mon = is_dec ? MON_JAN : i_item.month + 4'd1;
    assign prv_mon = is_jan ? MON_DEC : i_item.month - 4'd1;

    // Only February depends on the year, and it is always in the input year.
    assign cur_len = month_len(i_item.month, leap);
    assign nxt_len = month_len(nxt_mon, leap);
    assign prv_len = month_len(prv_mon, leap);

    assign date_ok = (i_item.year <= YEAR_MAX) && (cur_len != 5'd0)
                  && (i_item.day != 5'd0) && (i_item.day <= cur_len);

    assign wk_fwd  = {1'b0, i_item.day} + {1'b0, WEEK_LEN};
    assign wk_back = {1'b0, prv_len} + {1'b0, i_item.day} - {1'b0, WEEK_LEN};

    always_comb begin
        to_next = 1'b0;
        to_prev = 1'b0;
        st_day  = i_item.day;
        case (i_item.cmd)
            CMD_NEXT_DAY: begin
                if (i_item.day < cur_len) begin
                    st_day = i_item.day + 5'd1;
                end else begin
                    to_next = 1'b1;
                    st_day  = DAY_ONE;
                end
            end
            CMD_PREV_DAY: begin
                if (i_item.day > DAY_ONE) begin
                    st_day = i_item.day - 5'd1;
                end else begin
                    to_prev = 1'b1;
                    st_day  = prv_len;
                end
            end
            CMD_NEXT_WEEK: begin
                if (wk_fwd <= {1'b0, cur_len}) begin
                    st_day = wk_fwd[DayW-1:0];
                end else begin
                    to_next = 1'b1;
                    st_day  = wk_fwd[DayW-1:0] - cur_len;
                end
            end
            CMD_PREV_WEEK: begin
                if (i_item.day > WEEK_LEN) begin
                    st_day = i_item.day - WEEK_LEN;
                end else begin
                    to_prev = 1'b1;
                    st_day  = wk_back[DayW-1:0];
                end
            end
            CMD_NEXT_MON_BEGIN: begin
                to_next = 1'b1;
                st_day  = DAY_ONE;
            end
            CMD_PREV_MON_BEGIN: begin
                to_prev = 1'b1;
                st_day  = DAY_ONE;
            end
            CMD_NEXT_MON_END: begin
                to_next = 1'b1;
                st_day  = nxt_len;
            end
            CMD_PREV_MON_END: begin
                to_prev = 1'b1;
                st_day  = prv_len;
            end
            CMD_SNAP_END_UP: begin
                st_day = cur_len;
            end
            CMD_SNAP_END_DOWN: begin
                if (i_item.day != cur_len) begin
                    to_prev = 1'b1;
                    st_day  = prv_len;
                end
            end
            CMD_SNAP_BEGIN_UP: begin
                if (i_item.day != DAY_ONE) begin
                    to_next = 1'b1;
                    st_day  = DAY_ONE;
                end
            end
            CMD_SNAP_BEGIN_DOWN: begin
                st_day = DAY_ONE;
            end
            default: begin
                st_day = i_item.day;
            end
        endcase
    end

    assign out_range = (to_next && is_dec && (i_item.year == YEAR_MAX))
                    || (to_prev && is_jan && (i_item.year == '0));

    always_comb begin
        res.year   = i_item.year;
        res.month  = i_item.month;
        res.day    = i_item.day;
        res.status = ST_OK;
        if (!date_ok) begin
            res.status = ST_BAD_DATE;
        end else if (out_range) begin
            res.status = ST_RANGE;
        end else begin
            res.day = st_day;
            if (to_next) begin
                res.month = nxt_mon;
                if (is_dec) begin
                    res.year = i_item.year + 14'd1;
                end
            end else if (to_prev) begin
                res.month = prv_mon;
                if (is_jan) begin
                    res.year = i_item.year - 14'd1;
                end
            end
        end
    end

    assign o_res = res;

endmodule

[hdl/gregorian_date_stepper_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_stepper_top: Gregorian calendar date stepper
//
//   Channel   Dir   Payload                                  Handshake
//   i_cmd     in    cmd, year, month, day                    valid / ready
//   o_res     out   out_year, out_month, out_day, status     valid / ready
//
// One beat is accepted per cycle while i_cmd.ready is high; each command beat
// passes through the input register, then the result register.
// The stepping logic between the two registers is a single pass with one
// 14x13 constant multiply ahead of the input register.
// Synchronous active-low reset empties both registers; there is no other state.
// When the result is stalled, the input register still fills, and i_cmd.ready
// drops only while both registers hold beats.
// ----------------------------------------------------------------------------
module gregorian_date_stepper_top
    import gds_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    gds_cmd_if.sink  i_cmd,
    gds_res_if.source o_res
);

    logic    s1_valid;
    t_item   s1_item;
    logic    s1_adv;
    logic    out_adv;
    t_result step_res;
    logic    r_out_valid;
    t_result r_out;

    assign out_adv = !r_out_valid || o_res.ready;
    assign s1_adv  = !s1_valid || out_adv;

    gds_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.valid),
        .i_cmd   (i_cmd.cmd),
        .i_year  (i_cmd.year),
        .i_month (i_cmd.month),
        .i_day   (i_cmd.day),
        .i_adv   (s1_adv),
        .o_valid (s1_valid),
        .o_item  (s1_item)
    );

    gds_step u_step (
        .i_item (s1_item),
        .o_res  (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && s1_valid) begin
            r_out <= step_res;
        end
    end

    assign i_cmd.ready     = s1_adv;
    assign o_res.valid     = r_out_valid;
    assign o_res.out_year  = r_out.year;
    assign o_res.out_month = r_out.month;
    assign o_res.out_day   = r_out.day;
    assign o_res.status    = r_out.status;

endmodule

[hdl/gds_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_checker: port checks for the date stepper
// Watches both channels of the top level and flags broken handshakes,
// lost beats and out-of-range results.
// ----------------------------------------------------------------------------
module gds_checker
    import gds_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [13:0] i_out_year,
    input logic [3:0]  i_out_month,
    input logic [4:0]  i_out_day,
    input logic [1:0]  i_status
);

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
        && $stable({i_out_year, i_out_month, i_out_day, i_status}))
        else $error("result beat changed while stalled");

    // After an accepted command, the result channel must show a valid beat.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> ##2 i_out_valid)
        else $error("accepted command produced no result");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A good result has a month from 1 to 12, a day from 1 to 31 and a year within the supported years.
    a_ok_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_OK) |-> (i_out_year <= YEAR_MAX)
        && (i_out_month >= MON_JAN) && (i_out_month <= MON_DEC)
        && (i_out_day >= DAY_ONE) && (i_out_day <= 5'd31))
        else $error("ok status on an impossible date");

    // Status never carries the unused code.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_OK) || (i_status == ST_BAD_DATE)
        || (i_status == ST_RANGE))
        else $error("unknown status code");

endmodule

bind gregorian_date_stepper_top gds_checker u_gds_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_year  (o_res.out_year),
    .i_out_month (o_res.out_month),
    .i_out_day   (o_res.out_day),
    .i_status    (o_res.status)
);
